// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion helpers for the character buffer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PICB_ASSERT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("picb assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PICB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("picb assertion failed");

`endif

// ===== hw/rtl/picb_pkg.sv =====
// ----------------------------------------------------------------------------
// picb_pkg
// Types and constants shared by the character buffer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package picb_pkg;

  localparam int CMD_W    = 2;
  localparam int CHAR_W   = 8;
  localparam int POS_W    = 11;
  localparam int LENGTH_W = 11;
  localparam int STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_QUERY  = 2'd2
  } picb_cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } picb_status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } picb_state_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] ch;
    logic [POS_W-1:0]  pos;
  } picb_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0]   char_out;
    picb_status_t        status;
    logic [LENGTH_W-1:0] length_now;
  } picb_out_t;

  // Broadcast to every cell of the chain
  typedef struct packed {
    logic              ins_en;
    logic [CHAR_W-1:0] ch;
  } picb_cell_ctl_t;

endpackage

// ===== hw/rtl/picb_cell.sv =====
// ----------------------------------------------------------------------------
// picb_cell
// One character slot of the chain: keeps, loads or takes its left neighbor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module picb_cell
  import picb_pkg::*;
#(
  parameter int IDX_W = 10,
  parameter int IDX   = 0
) (
  input  logic                 clk,
  input  picb_cell_ctl_t       ctl_i,
  input  logic [IDX_W-1:0]     at_i,
  input  logic [IDX_W-1:0]     rd_idx_i,
  input  logic [CHAR_W-1:0]    left_i,
  output logic [CHAR_W-1:0]    data_o,
  output logic [CHAR_W-1:0]    read_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [CHAR_W-1:0] data_r;
  logic [CHAR_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl_i.ins_en) begin
      if (MY_IDX == at_i) begin
        data_nxt = ctl_i.ch;
      end else if (MY_IDX > at_i) begin
        data_nxt = left_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;
  // only the addressed cell drives its byte into the read tree; all others drive zero
  assign read_o = (MY_IDX == rd_idx_i) ? data_r : '0;

endmodule

// ===== hw/rtl/picb_read_tree.sv =====
// ----------------------------------------------------------------------------
// picb_read_tree
// Registered 4-ary OR tree that collects the one selected cell byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module picb_read_tree
  import picb_pkg::*;
#(
  parameter int LEAVES = 1024,
  parameter int LEVELS = 5
) (
  input  logic              clk,
  input  logic [CHAR_W-1:0] leaf_i [LEAVES],
  output logic [CHAR_W-1:0] root_o
);

  localparam int PAD_LEAVES = 4 ** LEVELS;
  localparam int INT_NODES  = (PAD_LEAVES - 1) / 3;
  localparam int ALL_NODES  = INT_NODES + PAD_LEAVES;

  // heap order: children of node n are 4n+1 .. 4n+4, leaves at the tail
  logic [CHAR_W-1:0] tree_r [INT_NODES];
  logic [CHAR_W-1:0] node_w [ALL_NODES];

  for (genvar n = 0; n < INT_NODES; n++) begin : g_int
    assign node_w[n] = tree_r[n];
    always_ff @(posedge clk) begin
      tree_r[n] <= node_w[4*n+1] | node_w[4*n+2] | node_w[4*n+3] | node_w[4*n+4];
    end
  end

  for (genvar j = 0; j < PAD_LEAVES; j++) begin : g_leaf
    if (j < LEAVES) begin : g_real
      assign node_w[INT_NODES+j] = leaf_i[j];
    end else begin : g_pad
      assign node_w[INT_NODES+j] = '0;
    end
  end

  assign root_o = tree_r[0];

endmodule

// ===== hw/rtl/positional_insert_char_buffer_core.sv =====
// ----------------------------------------------------------------------------
// positional_insert_char_buffer_core
// Ordered byte sequence with clear, positional insert and positional query.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one command transaction (clear, insert,
//   query); every command returns exactly one out_data transaction on
//   out_valid/out_ready, in command order.
//   Clear and insert edit the cell chain in the accept cycle (all cells shift
//   in parallel) and their result is registered in the output register (or
//   skid entry); one such command can be accepted each cycle in_ready is high.
//   A query selects one cell and waits for the registered 4-ary read tree,
//   LEVELS = ceil(log4(CAPACITY)) levels deep (5 for 1024), counted down in
//   ST_READ; the result is then registered, and no command is taken meanwhile.
//   An output register plus one skid entry let a new command be accepted
//   while a result waits; with both full, in_ready drops until out_ready.
//   Reset (rst_n low, synchronous) empties the sequence and drops all
//   pending results; cell contents are not cleared and need no sweep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module positional_insert_char_buffer_core
  import picb_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  picb_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output picb_out_t out_data
);

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int LEN_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;
  localparam int LEVELS = ($clog2(CAPACITY) + 1) / 2;
  localparam int CNT_W  = $clog2(LEVELS + 1);

  picb_state_t       state_r, state_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [IDX_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  picb_out_t         head_r, skid_r;
  logic              out_valid_r, skid_valid_r;

  picb_cell_ctl_t    ctl;
  logic [IDX_W-1:0]  ins_at;
  logic              accept;
  logic              res_v;
  picb_out_t         res;
  logic [CHAR_W-1:0] root;

  logic [CMP_W-1:0]  pos_x, len_x, pos_m1, len_out_x;
  logic              full, ins_ok, qry_ok;
  logic              head_full;

  logic [CHAR_W-1:0] data_w [CAPACITY];
  logic [CHAR_W-1:0] leaf_w [CAPACITY];

  // ---- decode ----
  assign pos_x  = CMP_W'(in_data.pos);
  assign len_x  = CMP_W'(len_r);
  assign pos_m1 = pos_x - CMP_W'(1);
  assign full   = (len_r == LEN_W'(CAPACITY));
  assign ins_ok = (pos_x != '0) && (pos_x <= len_x + CMP_W'(1));
  assign qry_ok = (pos_x != '0) && (pos_x <= len_x);
  assign len_out_x = CMP_W'(len_nxt);

  assign in_ready = rst_n && (state_r == ST_IDLE) && !skid_valid_r;
  assign accept   = in_valid && in_ready;

  // ---- next state ----
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_data.cmd == CMD_QUERY) && qry_ok) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (cnt_r == '0) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---- outputs of the controller ----
  always_comb begin
    res_v      = 1'b0;
    res        = '0;
    res.status = STAT_OK;
    ctl        = '0;
    ins_at     = pos_m1[IDX_W-1:0];
    len_nxt    = len_r;
    rd_idx_nxt = rd_idx_r;
    cnt_nxt    = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_v = 1'b1;
          case (in_data.cmd)
            CMD_CLEAR: begin
              len_nxt = '0;
            end
            CMD_INSERT: begin
              if (full) begin
                res.status = STAT_FULL;
              end else if (!ins_ok) begin
                res.status = STAT_RANGE;
              end else begin
                ctl.ins_en = 1'b1;
                ctl.ch     = in_data.ch;
                len_nxt    = len_r + LEN_W'(1);
              end
            end
            CMD_QUERY: begin
              if (qry_ok) begin
                res_v      = 1'b0;
                rd_idx_nxt = pos_m1[IDX_W-1:0];
                cnt_nxt    = CNT_W'(LEVELS);
              end else begin
                res.status = STAT_RANGE;
              end
            end
            default: res.status = STAT_RANGE;
          endcase
        end
      end
      ST_READ: begin
        if (cnt_r == '0) begin
          res_v        = 1'b1;
          res.char_out = root;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      default: ;
    endcase
    res.length_now = len_out_x[LENGTH_W-1:0];
  end

  // ---- controller registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      len_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= rd_idx_nxt;
  end

  // ---- output register with one skid entry ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_valid_r && out_ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_v;
      end
    end else if (res_v) begin
      if (out_valid_r) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_r && out_ready) begin
      head_r <= skid_valid_r ? skid_r : res;
    end else if (res_v) begin
      if (out_valid_r) begin
        skid_r <= res;
      end else begin
        head_r <= res;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = head_r;

  // ---- cell chain ----
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [CHAR_W-1:0] left_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_rest
      assign left_w = data_w[i-1];
    end
    picb_cell #(
      .IDX_W (IDX_W),
      .IDX   (i)
    ) u_cell (
      .clk      (clk),
      .ctl_i    (ctl),
      .at_i     (ins_at),
      .rd_idx_i (rd_idx_r),
      .left_i   (left_w),
      .data_o   (data_w[i]),
      .read_o   (leaf_w[i])
    );
  end

  picb_read_tree #(
    .LEAVES (CAPACITY),
    .LEVELS (LEVELS)
  ) u_read_tree (
    .clk    (clk),
    .leaf_i (leaf_w),
    .root_o (root)
  );

  // ---- assertions ----
  assign head_full = out_valid_r && (head_r.status == STAT_FULL);

  `PICB_ASSERT(a_len_bound, clk, rst_n, 1'b1, len_r <= LEN_W'(CAPACITY))
  `PICB_ASSERT(a_no_skid_overrun, clk, rst_n, res_v, !skid_valid_r)
  `PICB_ASSERT_NEXT(a_read_idx_held, clk, rst_n, (state_r == ST_READ), $stable(rd_idx_r))
  `PICB_ASSERT(a_full_len, clk, rst_n, head_full, head_r.length_now == LENGTH_W'(CAPACITY))
  `PICB_ASSERT_NEXT(a_ins_grows, clk, rst_n, ctl.ins_en, len_r == $past(len_r) + LEN_W'(1))

endmodule

// ===== sim/tb_positional_insert_char_buffer_core.sv =====
// ----------------------------------------------------------------------------
// tb_positional_insert_char_buffer_core
// Self-checking bench for the positional insert character buffer.
// A mirror of the byte sequence predicts the reply to every accepted command.
// A short table covers empty-buffer errors, insert at the front, middle and
// end, queries at both ends, out-of-range positions, the unused code and
// clear. Random traffic follows, and then a fill to capacity, where
// full-buffer inserts and wide-range queries are run. Both handshakes stall
// at random. One long receiver hold fills the output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_positional_insert_char_buffer_core;
  import picb_pkg::*;

  localparam int          CAPACITY    = 1024;
  localparam int          STALL_LIMIT = 3000;
  localparam int          HOLD_CYCLES = 300;
  localparam int          HOLD_AFTER  = 100;
  localparam int          DRAIN_WAIT  = 40;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;

  typedef struct {
    picb_in_t  item;
    bit        fixed;
    picb_out_t want;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  picb_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  picb_out_t out_data;

  // mirror of the sequence held by the block
  logic [CHAR_W-1:0] mirror_chars [CAPACITY];
  int                mirror_len;

  picb_out_t replies_due[$];
  dir_row_t  dir_rows[$];

  int  n_err;
  int  n_replies;
  int  n_clear, n_insert, n_query, n_unused, n_full;
  int  peak_len;
  int  stall_cycles;
  bit  steady;
  bit  hold_done;

  positional_insert_char_buffer_core #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Applies one command to the mirror and returns the reply it must produce.
  function automatic picb_out_t seq_apply(input picb_in_t item);
    picb_out_t res;
    int        p;
    p = int'(item.pos);
    res.char_out   = '0;
    res.status     = STAT_OK;
    case (item.cmd)
      CMD_CLEAR: begin
        mirror_len = 0;
      end
      CMD_INSERT: begin
        if (mirror_len >= CAPACITY) begin
          res.status = STAT_FULL;
        end else if (p == 0 || p > mirror_len + 1) begin
          res.status = STAT_RANGE;
        end else begin
          for (int i = mirror_len; i >= p; i--) mirror_chars[i] = mirror_chars[i-1];
          mirror_chars[p-1] = item.ch;
          mirror_len++;
        end
      end
      CMD_QUERY: begin
        if (p == 0 || p > mirror_len) begin
          res.status = STAT_RANGE;
        end else begin
          res.char_out = mirror_chars[p-1];
        end
      end
      default: begin
        res.status = STAT_RANGE;
      end
    endcase
    res.length_now = mirror_len[LENGTH_W-1:0];
    return res;
  endfunction

  function automatic void add_row(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                                  input logic [POS_W-1:0] pos, input bit fixed,
                                  input logic [CHAR_W-1:0] c_out, input picb_status_t st,
                                  input logic [LENGTH_W-1:0] len);
    dir_row_t row;
    row.item.cmd        = cmd;
    row.item.ch         = ch;
    row.item.pos        = pos;
    row.fixed           = fixed;
    row.want.char_out   = c_out;
    row.want.status     = st;
    row.want.length_now = len;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  // position in [lo, hi], with the two ends favored
  function automatic logic [POS_W-1:0] pos_in(input int lo, input int hi);
    int roll;
    roll = $urandom_range(99);
    if (roll < 25) return POS_W'(lo);
    if (roll < 50) return POS_W'(hi);
    return POS_W'($urandom_range(hi, lo));
  endfunction

  function automatic picb_in_t rand_cmd(input bit filling);
    picb_in_t item;
    int       roll;
    roll     = $urandom_range(99);
    item.cmd = CMD_QUERY;
    item.ch  = CHAR_W'($urandom);
    item.pos = POS_W'($urandom);
    if (filling) begin
      if (roll < 88) begin
        item.cmd = CMD_INSERT;
        item.pos = pos_in(1, mirror_len + 1);
      end else if (roll < 98) begin
        if (mirror_len > 0) item.pos = pos_in(1, mirror_len);
      end else if (roll < 99) begin
        item.cmd = CMD_INSERT;
      end
    end else begin
      if (roll < 4) begin
        item.cmd = CMD_CLEAR;
      end else if (roll < 52) begin
        item.cmd = CMD_INSERT;
        if ($urandom_range(9) != 0) item.pos = pos_in(1, mirror_len + 1);
      end else if (roll < 94) begin
        if (mirror_len > 0 && $urandom_range(9) != 0) item.pos = pos_in(1, mirror_len);
        else item.pos = POS_W'($urandom_range(mirror_len + 2, 0));
      end else if (roll < 96) begin
        item.cmd = CMD_UNUSED;
      end else begin
        item.cmd = CMD_W'($urandom);
      end
    end
    return item;
  endfunction

  // Offers one transaction, holds it until accepted, then records the reply due.
  task automatic send_cmd(input picb_in_t item, input bit fixed, input picb_out_t want);
    picb_out_t pred;
    while (!steady && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = seq_apply(item);
    replies_due.insert(replies_due.size(), fixed ? want : pred);
    case (item.cmd)
      CMD_CLEAR:  n_clear++;
      CMD_INSERT: n_insert++;
      CMD_QUERY:  n_query++;
      default:    n_unused++;
    endcase
    if (pred.status == STAT_FULL) n_full++;
    if (mirror_len > peak_len) peak_len = mirror_len;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  // receiver side
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && n_replies >= HOLD_AFTER) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 16);
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : reply_check
    picb_out_t want;
    if (rst_n && out_valid && out_ready) begin
      n_replies++;
      if (replies_due.size() == 0) begin
        $error("reply with nothing outstanding: %h", out_data);
        n_err++;
      end else begin
        want = replies_due.pop_front();
        if (out_data.char_out !== want.char_out) begin
          $error("char_out: expected %0h, got %0h", want.char_out, out_data.char_out);
          n_err++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          n_err++;
        end
        if (out_data.length_now !== want.length_now) begin
          $error("length_now: expected %0d, got %0d", want.length_now, out_data.length_now);
          n_err++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("no transaction for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    picb_in_t item;
    picb_out_t none;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data      <= '0;
    n_err        = 0;
    n_replies    = 0;
    n_clear      = 0;
    n_insert     = 0;
    n_query      = 0;
    n_unused     = 0;
    n_full       = 0;
    peak_len     = 0;
    mirror_len   = 0;
    steady       = 1'b0;
    hold_done    = 1'b0;
    none         = '0;

    // empty-buffer errors, then front / end / middle inserts
    add_row(CMD_QUERY,  8'h00, 11'd1,    1, 8'h00, STAT_RANGE, 11'd0);
    add_row(CMD_INSERT, 8'h3C, 11'd0,    1, 8'h00, STAT_RANGE, 11'd0);
    add_row(CMD_INSERT, 8'h3C, 11'd2,    1, 8'h00, STAT_RANGE, 11'd0);
    add_row(CMD_INSERT, 8'h00, 11'd1,    1, 8'h00, STAT_OK,    11'd1);
    add_row(CMD_INSERT, 8'hFF, 11'd1,    1, 8'h00, STAT_OK,    11'd2);
    add_row(CMD_INSERT, 8'hA5, 11'd3,    1, 8'h00, STAT_OK,    11'd3);
    add_row(CMD_INSERT, 8'h5A, 11'd2,    1, 8'h00, STAT_OK,    11'd4);
    add_row(CMD_QUERY,  8'h00, 11'd1,    0, 8'h00, STAT_OK,    11'd0);
    add_row(CMD_QUERY,  8'h00, 11'd2,    0, 8'h00, STAT_OK,    11'd0);
    add_row(CMD_QUERY,  8'h00, 11'd3,    0, 8'h00, STAT_OK,    11'd0);
    add_row(CMD_QUERY,  8'h00, 11'd4,    0, 8'h00, STAT_OK,    11'd0);
    add_row(CMD_QUERY,  8'h00, 11'd5,    1, 8'h00, STAT_RANGE, 11'd4);
    add_row(CMD_QUERY,  8'h00, 11'd0,    1, 8'h00, STAT_RANGE, 11'd4);
    add_row(CMD_QUERY,  8'hFF, 11'd2047, 1, 8'h00, STAT_RANGE, 11'd4);
    add_row(CMD_INSERT, 8'h11, 11'd6,    1, 8'h00, STAT_RANGE, 11'd4);
    add_row(CMD_INSERT, 8'hEE, 11'd2047, 1, 8'h00, STAT_RANGE, 11'd4);
    add_row(CMD_UNUSED, 8'hFF, 11'd1,    1, 8'h00, STAT_RANGE, 11'd4);
    add_row(CMD_CLEAR,  8'hFF, 11'd2047, 1, 8'h00, STAT_OK,    11'd0);
    add_row(CMD_QUERY,  8'h00, 11'd1,    1, 8'h00, STAT_RANGE, 11'd0);
    add_row(CMD_INSERT, 8'h81, 11'd1,    0, 8'h00, STAT_OK,    11'd0);
    add_row(CMD_QUERY,  8'h00, 11'd1,    0, 8'h00, STAT_OK,    11'd0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_cmd(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].want);

    // short sequences with frequent clears; the receiver hold lands in here
    repeat (150) send_cmd(rand_cmd(1'b0), 1'b0, none);
    wait_drained();

    // fill to capacity; no idling while the buffer is still short
    steady = 1'b1;
    while (mirror_len < CAPACITY) begin
      if (mirror_len >= 300) steady = 1'b0;
      send_cmd(rand_cmd(1'b1), 1'b0, none);
    end

    // full buffer: full status wins over a bad position
    item.cmd = CMD_INSERT;
    for (int i = 0; i < 5; i++) begin
      item.ch  = CHAR_W'($urandom);
      item.pos = (i == 0) ? 11'd1 : (i == 1) ? 11'd0 : (i == 2) ? 11'd1025 :
                 (i == 3) ? 11'd2047 : 11'd1024;
      send_cmd(item, 1'b0, none);
    end
    item.cmd = CMD_QUERY;
    for (int i = 0; i < 34; i++) begin
      item.ch  = CHAR_W'($urandom);
      item.pos = (i == 0) ? 11'd1024 : (i == 1) ? 11'd1025 : (i == 2) ? 11'd1 :
                 (i == 3) ? 11'd0 : POS_W'($urandom_range(1025, 0));
      send_cmd(item, 1'b0, none);
    end
    repeat (10) send_cmd(rand_cmd(1'b1), 1'b0, none);
    item.cmd = CMD_CLEAR;
    send_cmd(item, 1'b0, none);
    item.cmd = CMD_QUERY;
    item.pos = 11'd1;
    send_cmd(item, 1'b0, none);

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);

    if (replies_due.size() != 0) begin
      $error("%0d replies never arrived", replies_due.size());
      n_err++;
    end
    $display("Ran %0d inserts, %0d queries, %0d clears, %0d unused codes; peak length %0d.",
             n_insert, n_query, n_clear, n_unused, peak_len);
    $display("Inserts refused on a full buffer: %0d; replies checked: %0d.", n_full, n_replies);
    if (n_err == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/picb_pkg.sv
hw/rtl/picb_cell.sv
hw/rtl/picb_read_tree.sv
hw/rtl/positional_insert_char_buffer_core.sv
sim/tb_positional_insert_char_buffer_core.sv
